@@ design/bgc_pkg.sv @@
`timescale 1ns / 1ps

package bgc_pkg;

    localparam int BGC_MAX_VERTICES = 256;
    localparam int BGC_MAX_EDGES    = 1024;

    localparam int END_W  = 8;
    localparam int FUNC_W = 2;
    localparam int CFG_W  = 9;
    localparam int EDGE_W = 2 * END_W;

    localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CHECK = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    localparam logic [CFG_W-1:0] VCOUNT_RESET = 9'd256;

    typedef struct packed {
        logic start;
        logic take;
    } walk_req_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic is_bipartite;
    } walk_rsp_t;

endpackage

@@ design/bgc_edge_ram.sv @@
`timescale 1ns / 1ps

module bgc_edge_ram #(
    parameter int MAX_EDGES = bgc_pkg::BGC_MAX_EDGES,
    parameter int ADDR_W    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [ADDR_W-1:0]          wr_addr,
    input  logic [bgc_pkg::EDGE_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [ADDR_W-1:0]          rd_addr,
    output logic [bgc_pkg::EDGE_W-1:0] rd_data
);
    import bgc_pkg::*;

    logic [EDGE_W-1:0] mem [MAX_EDGES];
    logic [EDGE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/bgc_walk.sv @@
`timescale 1ns / 1ps

module bgc_walk #(
    parameter int MAX_VERTICES = bgc_pkg::BGC_MAX_VERTICES,
    parameter int MAX_EDGES    = bgc_pkg::BGC_MAX_EDGES,
    parameter int EADDR_W      = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
    parameter int EFILL_W      = $clog2(MAX_EDGES + 1)
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  bgc_pkg::walk_req_t         req,
    output bgc_pkg::walk_rsp_t         rsp,
    input  logic [bgc_pkg::CFG_W-1:0]  live_count,
    input  logic [EFILL_W-1:0]         edge_fill,
    output logic                       edge_rd_en,
    output logic [EADDR_W-1:0]         edge_rd_addr,
    input  logic [bgc_pkg::EDGE_W-1:0] edge_rd_data
);
    import bgc_pkg::*;

    localparam int CDEPTH = (MAX_VERTICES < 256) ? MAX_VERTICES : 256;
    localparam int VIDX_W = $clog2(CDEPTH);
    localparam int QCNT_W = $clog2(CDEPTH + 1);
    localparam int QENT_W = END_W + 1;

    localparam logic COLOR_A = 1'b0;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_POP  = 3'd2;
    localparam logic [2:0] S_ERD  = 3'd3;
    localparam logic [2:0] S_EGOT = 3'd4;
    localparam logic [2:0] S_ECHK = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]         state_reg,  state_next;
    logic [CFG_W-1:0]   start_reg,  start_next;
    logic [QCNT_W-1:0]  head_reg,   head_next;
    logic [QCNT_W-1:0]  tail_reg,   tail_next;
    logic [EFILL_W-1:0] eidx_reg,   eidx_next;
    logic [END_W-1:0]   other_reg,  other_next;
    logic               ok_reg,     ok_next;
    logic [CDEPTH-1:0]  vld_reg,    vld_next;

    logic               color_mem [CDEPTH];
    logic               color_rd_reg;
    logic [QENT_W-1:0]  queue_mem [CDEPTH];
    logic [QENT_W-1:0]  queue_rd_reg;

    logic               col_we, col_re, col_wdata;
    logic [VIDX_W-1:0]  col_waddr, col_raddr;
    logic               q_we, q_re;
    logic [VIDX_W-1:0]  q_waddr;
    logic [QENT_W-1:0]  q_wdata;

    logic [CFG_W-1:0]   scan_lim;
    logic [EFILL_W-1:0] eidx_inc;
    logic [END_W-1:0]   node, end_a, end_b, other;
    logic               mine, in_range, hit_a, hit_b;
    logic [VIDX_W-1:0]  start_idx, other_idx;

    assign scan_lim  = (live_count > CFG_W'(CDEPTH)) ? CFG_W'(CDEPTH) : live_count;
    assign eidx_inc  = eidx_reg + EFILL_W'(1);
    assign node      = queue_rd_reg[QENT_W-1:1];
    assign mine      = queue_rd_reg[0];
    assign end_a     = edge_rd_data[EDGE_W-1:END_W];
    assign end_b     = edge_rd_data[END_W-1:0];
    assign in_range  = ({1'b0, end_a} < live_count) && ({1'b0, end_b} < live_count);
    assign hit_a     = (end_a == node);
    assign hit_b     = (end_b == node);
    assign other     = hit_a ? end_b : end_a;
    assign start_idx = start_reg[VIDX_W-1:0];
    assign other_idx = other_reg[VIDX_W-1:0];

    always_comb begin
        state_next   = state_reg;
        start_next   = start_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        eidx_next    = eidx_reg;
        other_next   = other_reg;
        ok_next      = ok_reg;
        vld_next     = vld_reg;
        col_we       = 1'b0;
        col_waddr    = start_idx;
        col_wdata    = COLOR_A;
        col_re       = 1'b0;
        col_raddr    = other[VIDX_W-1:0];
        q_we         = 1'b0;
        q_waddr      = '0;
        q_wdata      = {END_W'(start_reg), COLOR_A};
        q_re         = 1'b0;
        edge_rd_en   = 1'b0;
        edge_rd_addr = eidx_reg[EADDR_W-1:0];

        unique case (state_reg)
            S_IDLE: begin
                if (req.start) begin
                    vld_next   = '0;
                    start_next = '0;
                    ok_next    = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (start_reg >= scan_lim) begin
                    state_next = S_DONE;
                end else if (vld_reg[start_idx]) begin
                    start_next = start_reg + CFG_W'(1);
                end else begin
                    col_we              = 1'b1;
                    vld_next[start_idx] = 1'b1;
                    q_we                = 1'b1;
                    head_next           = '0;
                    tail_next           = QCNT_W'(1);
                    state_next          = S_POP;
                end
            end
            S_POP: begin
                if (head_reg == tail_reg) begin
                    start_next = start_reg + CFG_W'(1);
                    state_next = S_SCAN;
                end else begin
                    q_re       = 1'b1;
                    head_next  = head_reg + QCNT_W'(1);
                    eidx_next  = '0;
                    state_next = (edge_fill == '0) ? S_POP : S_ERD;
                end
            end
            S_ERD: begin
                edge_rd_en = 1'b1;
                state_next = S_EGOT;
            end
            S_EGOT: begin
                if (in_range && (hit_a || hit_b)) begin
                    other_next = other;
                    col_re     = 1'b1;
                    state_next = S_ECHK;
                end else begin
                    eidx_next  = eidx_inc;
                    state_next = (eidx_inc == edge_fill) ? S_POP : S_ERD;
                end
            end
            S_ECHK: begin
                if (!vld_reg[other_idx]) begin
                    col_we              = 1'b1;
                    col_waddr           = other_idx;
                    col_wdata           = ~mine;
                    vld_next[other_idx] = 1'b1;
                    q_we                = 1'b1;
                    q_waddr             = tail_reg[VIDX_W-1:0];
                    q_wdata             = {other_reg, ~mine};
                    tail_next           = tail_reg + QCNT_W'(1);
                    eidx_next           = eidx_inc;
                    state_next          = (eidx_inc == edge_fill) ? S_POP : S_ERD;
                end else if (color_rd_reg == mine) begin
                    ok_next    = 1'b0;
                    state_next = S_DONE;
                end else begin
                    eidx_next  = eidx_inc;
                    state_next = (eidx_inc == edge_fill) ? S_POP : S_ERD;
                end
            end
            S_DONE: begin
                if (req.take) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            vld_reg   <= '0;
        end else begin
            state_reg <= state_next;
            vld_reg   <= vld_next;
        end
        start_reg <= start_next;
        head_reg  <= head_next;
        tail_reg  <= tail_next;
        eidx_reg  <= eidx_next;
        other_reg <= other_next;
        ok_reg    <= ok_next;
    end

    always_ff @(posedge aclk) begin
        if (col_we) begin
            color_mem[col_waddr] <= col_wdata;
        end
        if (col_re) begin
            color_rd_reg <= color_mem[col_raddr];
        end
        if (q_we) begin
            queue_mem[q_waddr] <= q_wdata;
        end
        if (q_re) begin
            queue_rd_reg <= queue_mem[head_reg[VIDX_W-1:0]];
        end
    end

    assign rsp.busy         = (state_reg != S_IDLE);
    assign rsp.done         = (state_reg == S_DONE);
    assign rsp.is_bipartite = ok_reg;

endmodule

@@ design/bipartite_graph_check_top.sv @@
`timescale 1ns / 1ps

// Bipartite check over a stored edge list.
// Input channel (s_valid/s_ready): s_func 0 adds edge (s_end_a, s_end_b),
// 1 runs a check, 2 empties the edge store, 3 is ignored. Add and clear
// take effect on acceptance and give no result. Bad or overflowing edges
// are dropped and flagged in the next check result.
// Result channel (m_valid/m_ready): one item per check, is_bipartite and
// input_error. Config channel (cfg_valid/cfg_ready): vertex_count, always
// ready; write only while idle.
// A check runs in a sequencer that shares one edge/colour compare step. It
// scans the vertices for uncoloured ones, walks each one's component through
// a queue and, for each vertex dequeued, reads every stored edge; on an
// endpoint hit it reads the other end's colour (edge RAM read, then colour
// RAM read).
// s_ready is low for the whole check and until its verdict moves into the
// output register; with a result still waiting there, a stalled receiver
// holds the next check's verdict and so blocks the input side.
// Reset (synchronous, active low) empties the edge store, clears the drop
// flag and sets vertex_count to 256. No clearing pass is needed.

module bipartite_graph_check_top #(
    parameter int MAX_VERTICES = bgc_pkg::BGC_MAX_VERTICES,
    parameter int MAX_EDGES    = bgc_pkg::BGC_MAX_EDGES
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [bgc_pkg::FUNC_W-1:0] s_func,
    input  logic [bgc_pkg::END_W-1:0]  s_end_a,
    input  logic [bgc_pkg::END_W-1:0]  s_end_b,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_is_bipartite,
    output logic                       m_input_error,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [bgc_pkg::CFG_W-1:0]  cfg_data
);
    import bgc_pkg::*;

    localparam int EADDR_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int EFILL_W = $clog2(MAX_EDGES + 1);

    logic [CFG_W-1:0]   vcount_reg;
    logic [EFILL_W-1:0] fill_reg;
    logic               dropped_reg;
    logic               err_hold_reg;
    logic               m_valid_reg, m_bip_reg, m_err_reg;

    logic [CFG_W-1:0]   live_count;
    logic               accept, is_add, add_ok, out_load;
    walk_req_t          wreq;
    walk_rsp_t          wrsp;
    logic               edge_rd_en;
    logic [EADDR_W-1:0] edge_rd_addr;
    logic [EDGE_W-1:0]  edge_rd_data;

    assign live_count = (32'(vcount_reg) > MAX_VERTICES) ? CFG_W'(MAX_VERTICES) : vcount_reg;
    assign s_ready    = !wrsp.busy;
    assign cfg_ready  = 1'b1;
    assign accept     = s_valid && s_ready;
    assign is_add     = accept && (s_func == FUNC_ADD);
    assign add_ok     = (fill_reg != EFILL_W'(MAX_EDGES))
                        && ({1'b0, s_end_a} < live_count)
                        && ({1'b0, s_end_b} < live_count);
    assign out_load   = wrsp.done && (!m_valid_reg || m_ready);

    assign wreq.start = accept && (s_func == FUNC_CHECK);
    assign wreq.take  = out_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg  <= VCOUNT_RESET;
            fill_reg    <= '0;
            dropped_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                vcount_reg <= cfg_data;
            end
            if (is_add) begin
                if (add_ok) begin
                    fill_reg <= fill_reg + EFILL_W'(1);
                end else begin
                    dropped_reg <= 1'b1;
                end
            end
            if (accept && (s_func == FUNC_CLEAR)) begin
                fill_reg <= '0;
            end
            if (wreq.start) begin
                dropped_reg <= 1'b0;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (wreq.start) begin
            err_hold_reg <= dropped_reg;
        end
        if (out_load) begin
            m_bip_reg <= wrsp.is_bipartite;
            m_err_reg <= err_hold_reg;
        end
    end

    bgc_edge_ram #(
        .MAX_EDGES (MAX_EDGES),
        .ADDR_W    (EADDR_W)
    ) u_edge_ram (
        .aclk    (aclk),
        .wr_en   (is_add && add_ok),
        .wr_addr (fill_reg[EADDR_W-1:0]),
        .wr_data ({s_end_a, s_end_b}),
        .rd_en   (edge_rd_en),
        .rd_addr (edge_rd_addr),
        .rd_data (edge_rd_data)
    );

    bgc_walk #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES),
        .EADDR_W      (EADDR_W),
        .EFILL_W      (EFILL_W)
    ) u_walk (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .req          (wreq),
        .rsp          (wrsp),
        .live_count   (live_count),
        .edge_fill    (fill_reg),
        .edge_rd_en   (edge_rd_en),
        .edge_rd_addr (edge_rd_addr),
        .edge_rd_data (edge_rd_data)
    );

    assign m_valid        = m_valid_reg;
    assign m_is_bipartite = m_bip_reg;
    assign m_input_error  = m_err_reg;

endmodule

@@ design/bgc_checker.sv @@
`timescale 1ns / 1ps

module bgc_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic [bgc_pkg::FUNC_W-1:0] s_func,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic                       m_is_bipartite,
    input logic                       m_input_error
);
    import bgc_pkg::*;

    // result item held while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_is_bipartite) && $stable(m_input_error))
        else $error("result item changed while stalled");

    // a check blocks the input side at least for the next cycle
    a_check_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_func == FUNC_CHECK) |=> !s_ready)
        else $error("input accepted straight after a check item");

    // a new result only appears at the end of a check
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result item without a running check");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind bipartite_graph_check_top bgc_checker u_bgc_checker (.*);
